// ===== src/hrhc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhc_pkg
// Types and character constants for the HTTP request header checker.
// ----------------------------------------------------------------------------
package hrhc_pkg;

	typedef enum logic [4:0] {
		PH_REQ   = 5'b00001,
		PH_NAME  = 5'b00010,
		PH_VALUE = 5'b00100,
		PH_DONE  = 5'b01000,
		PH_BAD   = 5'b10000
	} phase_t;

	localparam logic [3:0] VER_LEN       = 4'd8;
	localparam logic [3:0] VER_MISMATCH  = 4'd15;
	localparam logic [2:0] NAME_LEN      = 3'd4;
	localparam logic [2:0] NAME_MISMATCH = 3'd7;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] token_count;
		logic       inside_token;
		logic       method_upper_ok;
		logic       target_slash_ok;
		logic [3:0] ver_idx;
		logic [2:0] name_idx;
		logic       name_nonempty;
		logic       value_nonblank;
		logic       host_seen;
		logic       pending_cr;
		logic       line_empty;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:           PH_REQ,
		token_count:     3'd0,
		inside_token:    1'b0,
		method_upper_ok: 1'b1,
		target_slash_ok: 1'b0,
		ver_idx:         4'd0,
		name_idx:        3'd0,
		name_nonempty:   1'b0,
		value_nonblank:  1'b0,
		host_seen:       1'b0,
		pending_cr:      1'b0,
		line_empty:      1'b1
	};

endpackage

// ===== src/hrhc_update.sv =====
// ----------------------------------------------------------------------------
// hrhc_update
// Per-byte next-state and verdict logic of the request header checker.
// ----------------------------------------------------------------------------
module hrhc_update (
	input  hrhc_pkg::state_t cur,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output hrhc_pkg::state_t nxt,
	output logic             bad
);
	import hrhc_pkg::*;

	localparam logic [7:0] VER_TEXT [8] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31
	};
	localparam logic [7:0] HOST_TEXT [4] = '{8'h68, 8'h6f, 8'h73, 8'h74};

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0d]};
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return c inside {[8'h41:8'h5a]};
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return c inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39], 8'h2d, 8'h5f};
	endfunction

	function automatic state_t start_line(input state_t s);
		state_t r;
		r = s;
		r.name_idx       = 3'd0;
		r.name_nonempty  = 1'b0;
		r.value_nonblank = 1'b0;
		r.line_empty     = 1'b1;
		return r;
	endfunction

	function automatic state_t take_data(input state_t s, input logic [7:0] c);
		state_t     r;
		logic [7:0] low;
		r   = s;
		low = is_upper(c) ? c + 8'd32 : c;
		case (s.phase)
			PH_REQ: begin
				r.line_empty = 1'b0;
				if (is_ws(c)) begin
					r.inside_token = 1'b0;
				end else begin
					if (!s.inside_token) begin
						r.inside_token = 1'b1;
						if (s.token_count < 3'd4)
							r.token_count = s.token_count + 3'd1;
						if (r.token_count == 3'd2)
							r.target_slash_ok = (c == 8'h2f);
					end
					if (r.token_count == 3'd1 && !is_upper(c))
						r.method_upper_ok = 1'b0;
					if (r.token_count == 3'd3) begin
						if (s.ver_idx < VER_LEN && c == VER_TEXT[s.ver_idx[2:0]])
							r.ver_idx = s.ver_idx + 4'd1;
						else
							r.ver_idx = VER_MISMATCH;
					end
				end
			end
			PH_NAME: begin
				r.line_empty = 1'b0;
				if (c == 8'h3a) begin
					r.phase = s.name_nonempty ? PH_VALUE : PH_BAD;
				end else if (is_name_char(c)) begin
					r.name_nonempty = 1'b1;
					if (s.name_idx < NAME_LEN && low == HOST_TEXT[s.name_idx[1:0]])
						r.name_idx = s.name_idx + 3'd1;
					else
						r.name_idx = NAME_MISMATCH;
				end else begin
					r.phase = PH_BAD;
				end
			end
			PH_VALUE: begin
				r.line_empty = 1'b0;
				if (c != 8'h20 && c != 8'h09)
					r.value_nonblank = 1'b1;
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	function automatic state_t end_line(input state_t s);
		state_t r;
		r = s;
		case (s.phase)
			PH_REQ: begin
				r.phase = (s.token_count == 3'd3 && s.method_upper_ok &&
					s.target_slash_ok && s.ver_idx == VER_LEN) ? PH_NAME : PH_BAD;
				r = start_line(r);
			end
			PH_NAME: begin
				r.phase = s.line_empty ? PH_DONE : PH_BAD;
				r = start_line(r);
			end
			PH_VALUE: begin
				if (s.name_idx == NAME_LEN && s.value_nonblank)
					r.host_seen = 1'b1;
				r.phase = PH_NAME;
				r = start_line(r);
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	state_t stepped;
	logic   line_open;

	always_comb begin
		stepped = cur;
		if (cur.phase inside {PH_REQ, PH_NAME, PH_VALUE}) begin
			if (cur.pending_cr) begin
				stepped.pending_cr = 1'b0;
				if (data_byte == CH_LF) begin
					stepped = end_line(stepped);
				end else begin
					stepped = take_data(stepped, CH_CR);
					if (data_byte == CH_CR)
						stepped.pending_cr = 1'b1;
					else
						stepped = take_data(stepped, data_byte);
				end
			end else if (data_byte == CH_CR) begin
				stepped.pending_cr = 1'b1;
			end else begin
				stepped = take_data(stepped, data_byte);
			end
		end
	end

	assign line_open = !((stepped.phase == PH_NAME || stepped.phase == PH_VALUE) &&
		stepped.line_empty && !stepped.pending_cr);

	always_comb begin
		if (stepped.phase == PH_DONE)
			bad = !stepped.host_seen;
		else if (!line_open)
			bad = !stepped.host_seen;
		else
			bad = 1'b1;
	end

	assign nxt = final_byte ? STATE_RESET : stepped;

endmodule

// ===== src/http_request_header_checker.sv =====
// ----------------------------------------------------------------------------
// http_request_header_checker
// Streams an HTTP/1.1 request header one byte per transfer and returns one
// ok/bad verdict for each request, on the byte marked final_byte.
//
// Input channel: data_byte, final_byte with in_valid / in_stall. Output
// channel: verdict with out_valid / out_stall; verdict 0 is ok, 1 is bad.
// Bytes without final_byte produce no output transfer.
// A byte is held in the input register, where the per-byte state
// update runs; its verdict is then loaded into the output register,
// from which it can transfer out.
// Throughput: one byte per cycle while in_stall is low; the state update
// between the input register and the parse state register is combinational.
// After the final byte the parse state returns to its reset value, so the
// next request may follow in the next cycle.
// Reset (arst_n low) clears the valid bits of both registers and the parse state.
// While the receiver stalls, a held verdict stays put; non-final bytes keep
// flowing, and in_stall rises only when a final byte waits behind it.
// ----------------------------------------------------------------------------
module http_request_header_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       verdict
);
	import hrhc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	state_t     state_q;
	state_t     state_nxt;
	logic       bad_nxt;
	logic       out_valid_q;
	logic       verdict_q;
	logic       advance;
	logic       load_out;

	assign in_stall = valid_s1 && final_s1 && out_valid_q && out_stall;
	assign advance  = !in_stall;
	assign load_out = advance && valid_s1 && final_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			byte_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	hrhc_update u_update (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.final_byte (final_s1),
		.nxt        (state_nxt),
		.bad        (bad_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			verdict_q <= bad_nxt;
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	a_reset_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (state_q == STATE_RESET))
		else $error("parse state not cleared after final byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && final_s1 && valid_s1))
		else $error("input stalled without a blocked verdict");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && final_s1))
		else $error("verdict presented without a final byte");

	a_ver_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.ver_idx <= VER_LEN) || (state_q.ver_idx == VER_MISMATCH))
		else $error("version match index out of range");

	a_name_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.name_idx <= NAME_LEN) || (state_q.name_idx == NAME_MISMATCH))
		else $error("name match index out of range");

endmodule
